### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while reset is held.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
// Clocked next-cycle implication check, disabled while reset is held.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`endif

### hw/rtl/salc_pkg.sv
// Package with types, constants and codes for the cache controller.
package salc_pkg;

    localparam int Lines    = 256;
    localparam int LineBits = 8;
    localparam logic [7:0] AgeMax = 8'd255;

    localparam logic [2:0] ActRead  = 3'd0;
    localparam logic [2:0] ActWrite = 3'd1;
    localparam logic [2:0] ActFill  = 3'd2;
    localparam logic [2:0] ActWback = 3'd3;
    localparam logic [2:0] ActDrop  = 3'd4;

    localparam logic [1:0] RegBlock = 2'd0;
    localparam logic [1:0] RegSets  = 2'd1;
    localparam logic [1:0] RegWays  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] start_address;
        logic [8:0]  word_count;
        logic        hit;
        logic        config_error;
        logic        last;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE_RD,
        ST_AGE_WR,
        ST_EMIT_EVICT,
        ST_EMIT_FILL,
        ST_EMIT_CPU
    } t_state;

endpackage

### hw/rtl/salc_mem.sv
// Tag, age and dirty storage with registered reads and one write port each.
module salc_mem import salc_pkg::*; (
    input  logic                i_clk,
    input  logic [LineBits-1:0] i_raddr,
    output logic [15:0]         o_tag,
    output logic [7:0]          o_age,
    output logic                o_dirty,
    input  logic                i_tag_we,
    input  logic [LineBits-1:0] i_tag_waddr,
    input  logic [15:0]         i_tag_wdata,
    input  logic                i_age_we,
    input  logic [LineBits-1:0] i_age_waddr,
    input  logic [7:0]          i_age_wdata,
    input  logic                i_dirty_we,
    input  logic [LineBits-1:0] i_dirty_waddr,
    input  logic                i_dirty_wdata
);

    logic [15:0] r_tag   [Lines];
    logic [7:0]  r_age   [Lines];
    logic        r_dirty [Lines];

    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            r_tag[i_tag_waddr] <= i_tag_wdata;
        end
        if (i_age_we) begin
            r_age[i_age_waddr] <= i_age_wdata;
        end
        if (i_dirty_we) begin
            r_dirty[i_dirty_waddr] <= i_dirty_wdata;
        end
        o_tag   <= r_tag[i_raddr];
        o_age   <= r_age[i_raddr];
        o_dirty <= r_dirty[i_raddr];
    end

endmodule

### hw/rtl/set_assoc_lru_cache_controller.sv
// Top level of the set-associative write-back LRU cache controller.
//
//  channel   signals                               direction  flow control
//  request   i_start, o_busy, i_req                in         start while not busy
//  result    o_rsp_valid, o_rsp                    out        strobe, no stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_*     in         valid / ready
//
// An access walks the set through one shared tag compare and age unit: a
// read step, a compare step per way (stopping early on a hit), a decide
// step, a read and a write step per way to age the set, then the result
// beats. An illegal geometry puts its beat out in the cycle after the start
// beat, and the block is idle again in the cycle after that beat. The
// single read port of the tag and age memories sets the pace of this walk.
// Reset is synchronous and active low and clears the valid and touched
// bits; dirty bits are gated with valid and ages with a touched bit, so a
// line never written reads as clean with age zero. The result side cannot
// stall, so beats go out one per cycle.
module set_assoc_lru_cache_controller import salc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    // Configuration registers.
    logic [3:0] r_lbw, r_lsets;
    logic [8:0] r_ways;

    // Per-line valid bits in flip-flops, cleared by reset.
    logic [Lines-1:0] r_valid;
    // Age has no reset of its own: a line's age is written on every touch
    // and reads as zero while the line has never been touched. A separate
    // touched bit tracks that.
    logic [Lines-1:0] r_aged;

    t_state r_state, n_state;
    t_req   r_req;
    logic [8:0] r_w;          // way counter
    logic       r_found, r_free;
    logic [7:0] r_way;        // matched, free or victim way
    logic [7:0] r_best;
    logic [15:0] r_vtag;
    logic       r_vdirty;
    logic       r_bad;

    // Geometry decode.
    logic       geo_bad;
    assign geo_bad = (r_lbw > 4'd8) || (r_lsets > 4'd8) || (r_ways == 9'd0) ||
                     ((17'(r_ways) << r_lsets) > 17'(Lines));

    logic [15:0] addr_q;
    logic [4:0]  shift;
    logic [7:0]  set_idx;
    logic [15:0] tag_q;
    logic [7:0]  set_base;
    assign addr_q   = r_req.address;
    assign shift    = 5'(r_lbw) + 5'(r_lsets);
    assign set_idx  = 8'((addr_q >> r_lbw) & ((16'd1 << r_lsets) - 16'd1));
    assign tag_q    = addr_q >> shift;
    assign set_base = 8'(set_idx * r_ways);

    // Memory and line address of the current way.
    logic [LineBits-1:0] line_cur;
    assign line_cur = set_base + r_w[7:0];

    logic [15:0] m_tag;
    logic [7:0]  m_age;
    logic        m_dirty;
    logic        tag_we, age_we, dirty_we, dirty_wd;
    logic [LineBits-1:0] sel_line;
    logic [7:0] age_wd;
    logic [LineBits-1:0] r_rline;

    salc_mem u_mem (
        .i_clk        (i_clk),
        .i_raddr      (line_cur),
        .o_tag        (m_tag),
        .o_age        (m_age),
        .o_dirty      (m_dirty),
        .i_tag_we     (tag_we),
        .i_tag_waddr  (sel_line),
        .i_tag_wdata  (tag_q),
        .i_age_we     (age_we),
        .i_age_waddr  (r_rline),
        .i_age_wdata  (age_wd),
        .i_dirty_we   (dirty_we),
        .i_dirty_waddr(sel_line),
        .i_dirty_wdata(dirty_wd)
    );

    assign sel_line = set_base + r_way;

    // Values of the line read in the previous cycle, dirty gated by valid and age by the touched bit.
    logic        rd_valid;
    logic [7:0]  rd_age;
    logic        rd_dirty;
    assign rd_valid = r_valid[r_rline];
    assign rd_age   = r_aged[r_rline] ? m_age : 8'd0;
    assign rd_dirty = rd_valid & m_dirty;

    logic [8:0] last_way;
    assign last_way = r_ways - 9'd1;
    logic at_end;
    assign at_end = (r_w == last_way);

    // During the scan the read address runs one way ahead, so the line that
    // arrives from the memory belongs to way r_w - 1.
    logic       scan_hit;
    logic [7:0] scan_way;
    logic       scan_end;
    assign scan_hit = rd_valid && (m_tag == tag_q);
    assign scan_way = 8'(r_w - 9'd1);
    assign scan_end = (r_w == r_ways);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_start) n_state = geo_bad ? ST_EMIT_CPU : ST_SCAN_RD;
            ST_SCAN_RD:    n_state = ST_SCAN;
            ST_SCAN:       n_state = (scan_end || scan_hit) ? ST_DECIDE : ST_SCAN;
            ST_DECIDE:     n_state = ST_AGE_RD;
            ST_AGE_RD:     n_state = ST_AGE_WR;
            ST_AGE_WR:     n_state = at_end ?
                               (r_found ? ST_EMIT_CPU :
                                (r_free ? ST_EMIT_FILL : ST_EMIT_EVICT)) : ST_AGE_RD;
            ST_EMIT_EVICT: n_state = ST_EMIT_FILL;
            ST_EMIT_FILL:  n_state = ST_EMIT_CPU;
            ST_EMIT_CPU:   n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        tag_we   = 1'b0;
        dirty_we = 1'b0;
        dirty_wd = r_req.mode;
        age_we   = 1'b0;
        age_wd   = 8'd0;
        if (r_state == ST_DECIDE && !r_bad) begin
            tag_we   = !r_found;
            dirty_we = !r_found || r_req.mode;
        end
        if (r_state == ST_AGE_WR) begin
            age_we = 1'b1;
            age_wd = (r_rline == sel_line) ? 8'd0 :
                     ((rd_age == AgeMax) ? AgeMax : rd_age + 8'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lbw   <= 4'd0;
            r_lsets <= 4'd0;
            r_ways  <= 9'd1;
            r_valid <= '0;
            r_aged  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    RegBlock: r_lbw   <= i_cfg_data[3:0];
                    RegSets:  r_lsets <= i_cfg_data[3:0];
                    RegWays:  r_ways  <= i_cfg_data;
                    default:  r_ways  <= r_ways;
                endcase
            end
            if (tag_we) begin
                r_valid[sel_line] <= 1'b1;
            end
            if (age_we) begin
                r_aged[r_rline] <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rline <= line_cur;
        case (r_state)
            ST_IDLE: begin
                r_req   <= i_req;
                r_bad   <= geo_bad;
                r_w     <= 9'd0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
                r_way   <= 8'd0;
                r_best  <= 8'd0;
            end
            ST_SCAN_RD: begin
                // Way zero is being read; the address moves on to way one.
                r_w <= 9'd1;
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    r_found <= 1'b1;
                    r_way   <= scan_way;
                end else if (!rd_valid && !r_free) begin
                    r_free <= 1'b1;
                    r_way  <= scan_way;
                end else if (!r_free && rd_age >= r_best) begin
                    r_best   <= rd_age;
                    r_way    <= scan_way;
                    r_vtag   <= m_tag;
                    r_vdirty <= rd_dirty;
                end
                r_w <= r_w + 9'd1;
            end
            ST_DECIDE: begin
                r_w <= 9'd0;
            end
            ST_AGE_WR: begin
                if (!at_end) begin
                    r_w <= r_w + 9'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Result beats.
    always_comb begin
        o_rsp_valid = 1'b0;
        o_rsp = '0;
        o_rsp.word_count = 9'd1;
        case (r_state)
            ST_EMIT_EVICT: begin
                o_rsp_valid = 1'b1;
                o_rsp.action = r_vdirty ? ActWback : ActDrop;
                o_rsp.start_address = 16'((32'(r_vtag) << shift) |
                                          (32'(set_idx) << r_lbw));
                o_rsp.word_count = 9'(10'd1 << r_lbw);
            end
            ST_EMIT_FILL: begin
                o_rsp_valid = 1'b1;
                o_rsp.action = ActFill;
                o_rsp.start_address = (addr_q >> r_lbw) << r_lbw;
                o_rsp.word_count = 9'(10'd1 << r_lbw);
            end
            ST_EMIT_CPU: begin
                o_rsp_valid = 1'b1;
                o_rsp.last = 1'b1;
                if (r_bad) begin
                    o_rsp.config_error = 1'b1;
                    o_rsp.action = ActRead;
                end else begin
                    o_rsp.action = r_req.mode ? ActWrite : ActRead;
                    o_rsp.start_address = addr_q;
                    o_rsp.hit = r_found;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_start;

endmodule

### hw/rtl/salc_checker.sv
// Port-level checker for the cache controller, bound to the top level.
`include "assert_macros.svh"
module salc_checker import salc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp,
    input logic o_cfg_ready
);
    `CHK_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `CHK_IMPL(a_err_single, i_clk, i_rst_n, o_rsp_valid && o_rsp.config_error, o_rsp.last)
    `CHK_NEXT(a_idle_after_last, i_clk, i_rst_n, o_rsp_valid && o_rsp.last, !o_busy)
    `CHK_IMPL(a_no_cfg_busy, i_clk, i_rst_n, o_busy, !o_cfg_ready)
endmodule

bind set_assoc_lru_cache_controller salc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_rsp_valid(o_rsp_valid), .o_rsp(o_rsp), .o_cfg_ready(o_cfg_ready)
);
